// File: hw/rtl/leb_pkg.sv
// Shared types and constants of the line edit buffer.
package leb_pkg;

  // Default storage depth of the text memory
  localparam int unsigned BUF_DEPTH_DEF = 256;

  // Printable key code window for the catch-all key class
  localparam logic [9:0] KEY_LOW  = 10'd32;
  localparam logic [9:0] KEY_HIGH = 10'd127;

  // Reset value of the field length limit
  localparam logic [7:0] MAX_LENGTH_RST = 8'd255;

  // Request opcodes
  localparam logic [1:0] OP_KEY     = 2'd0;
  localparam logic [1:0] OP_FOCUS   = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;
  localparam logic [1:0] OP_READ    = 2'd3;

  // Key classes
  localparam logic [2:0] KC_ENTER = 3'd0;
  localparam logic [2:0] KC_HOME  = 3'd1;
  localparam logic [2:0] KC_END   = 3'd2;
  localparam logic [2:0] KC_DEL   = 3'd3;
  localparam logic [2:0] KC_BKSP  = 3'd4;
  localparam logic [2:0] KC_LEFT  = 3'd5;
  localparam logic [2:0] KC_RIGHT = 3'd6;
  localparam logic [2:0] KC_OTHER = 3'd7;

  // Focus modes
  localparam logic [1:0] FM_IDLE   = 2'd0;
  localparam logic [1:0] FM_EDIT   = 2'd1;
  localparam logic [1:0] FM_COMMIT = 2'd2;

  // One input request
  typedef struct packed {
    logic [1:0] opcode;
    logic [2:0] key_class;
    logic [9:0] key_code;
    logic [7:0] typed_char;
    logic       pressed;
    logic [7:0] read_index;
  } leb_item_t;

  // One result
  typedef struct packed {
    logic       handled;
    logic       commit_pending;
    logic       editing;
    logic [7:0] cursor_pos;
    logic [7:0] text_length;
    logic [7:0] read_char;
  } leb_result_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic step;
    logic wr;
    logic load;
  } leb_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic start_shift;
    logic busy;
    logic out_free;
  } leb_status_t;

endpackage

// File: hw/rtl/leb_if.sv
// Request and result channel interfaces of the line edit buffer.
interface leb_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [2:0] key_class;
  logic [9:0] key_code;
  logic [7:0] typed_char;
  logic       pressed;
  logic [7:0] read_index;

  modport source (output valid, opcode, key_class, key_code, typed_char, pressed,
                  read_index, input ready);
  modport sink (input valid, opcode, key_class, key_code, typed_char, pressed,
                read_index, output ready);
endinterface

interface leb_out_if;
  logic       valid;
  logic       ready;
  logic       handled;
  logic       commit_pending;
  logic       editing;
  logic [7:0] cursor_pos;
  logic [7:0] text_length;
  logic [7:0] read_char;

  modport source (output valid, handled, commit_pending, editing, cursor_pos,
                  text_length, read_char, input ready);
  modport sink (input valid, handled, commit_pending, editing, cursor_pos,
                text_length, read_char, output ready);
endinterface

// File: hw/rtl/leb_ctrl.sv
// Sequencing state machine of the line edit buffer.
module leb_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  leb_pkg::leb_status_t sts,
  output leb_pkg::leb_cmd_t    cmd
);
  import leb_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_STEP = 4'b0010,
    ST_WR   = 4'b0100,
    ST_FIN  = 4'b1000
  } leb_state_t;

  leb_state_t state_r, state_nxt;

  assign in_ready   = (state_r == ST_IDLE);
  assign cmd.accept = in_ready && in_valid;
  assign cmd.step   = (state_r == ST_STEP);
  assign cmd.wr     = (state_r == ST_WR);
  assign cmd.load   = (state_r == ST_FIN) && sts.out_free;

  // Advance through accept, shift loop and result hand-off
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = sts.start_shift ? ST_STEP : ST_FIN;
      end
      ST_STEP: begin
        state_nxt = sts.busy ? ST_WR : ST_FIN;
      end
      ST_WR: begin
        state_nxt = ST_STEP;
      end
      ST_FIN: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: hw/rtl/leb_dp.sv
// Datapath of the line edit buffer: edit state, text memory, shifter, result register.
module leb_dp #(
  parameter int unsigned BUF_DEPTH = leb_pkg::BUF_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [7:0]           cfg_data,
  input  leb_pkg::leb_item_t   item,
  input  leb_pkg::leb_cmd_t    cmd,
  output leb_pkg::leb_status_t sts,
  output logic                 out_valid,
  input  logic                 out_ready,
  output leb_pkg::leb_result_t result
);
  import leb_pkg::*;

  localparam int unsigned AW = $clog2(BUF_DEPTH);
  localparam logic [7:0]  CAP = 8'((BUF_DEPTH < 255) ? BUF_DEPTH : 255);

  logic [7:0]  max_length_r;
  logic [1:0]  focus_r, focus_nxt;
  logic [7:0]  cursor_r, cursor_nxt;
  logic [7:0]  length_r, length_nxt;
  logic [7:0]  ptr_r, ptr_nxt;
  logic [7:0]  lim_r, lim_nxt;
  logic        ins_r, ins_nxt;
  logic        del_nxt;
  logic        handled_r, handled_nxt;
  logic        rd_ok_r, rd_ok_nxt;
  logic [7:0]  ch_r;
  logic        out_valid_r;
  leb_result_t result_r;

  logic [7:0]  mem [BUF_DEPTH];
  logic [7:0]  rdata_r;
  logic        mem_we, mem_re;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]  wdata;
  logic [7:0]  cur_c;
  logic        printable;

  // Hold the field length limit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_length_r <= MAX_LENGTH_RST;
    end else if (cfg_we) begin
      max_length_r <= cfg_data;
    end
  end

  assign cur_c     = (cursor_r > length_r) ? length_r : cursor_r;
  assign printable = (item.typed_char != 8'd0) && (item.key_code >= KEY_LOW) &&
                     (item.key_code <= KEY_HIGH);

  // Decode the request against the current edit state
  always_comb begin
    focus_nxt   = focus_r;
    cursor_nxt  = cursor_r;
    length_nxt  = length_r;
    handled_nxt = 1'b0;
    rd_ok_nxt   = 1'b0;
    ins_nxt     = 1'b0;
    del_nxt     = 1'b0;
    ptr_nxt     = cur_c;
    lim_nxt     = cur_c;
    unique case (item.opcode)
      OP_KEY: begin
        priority if (focus_r != FM_EDIT) begin
          handled_nxt = 1'b0;
        end else if (item.key_class == KC_ENTER) begin
          focus_nxt = FM_COMMIT;
        end else if (item.key_class == KC_OTHER && !printable) begin
          handled_nxt = 1'b0;
        end else if (!item.pressed) begin
          handled_nxt = 1'b1;
        end else begin
          handled_nxt = 1'b1;
          cursor_nxt  = cur_c;
          unique case (item.key_class)
            KC_HOME: cursor_nxt = 8'd0;
            KC_END:  cursor_nxt = length_r;
            KC_DEL: begin
              if (cur_c < length_r) begin
                del_nxt    = 1'b1;
                length_nxt = length_r - 8'd1;
                ptr_nxt    = cur_c;
                lim_nxt    = length_r - 8'd1;
              end
            end
            KC_BKSP: begin
              if (cur_c != 8'd0) begin
                del_nxt    = 1'b1;
                cursor_nxt = cur_c - 8'd1;
                length_nxt = length_r - 8'd1;
                ptr_nxt    = cur_c - 8'd1;
                lim_nxt    = length_r - 8'd1;
              end
            end
            KC_LEFT: begin
              if (cur_c != 8'd0) cursor_nxt = cur_c - 8'd1;
            end
            KC_RIGHT: begin
              if (cur_c < length_r) cursor_nxt = cur_c + 8'd1;
            end
            default: begin
              if (cur_c < max_length_r && length_r < CAP) begin
                ins_nxt    = 1'b1;
                cursor_nxt = cur_c + 8'd1;
                length_nxt = length_r + 8'd1;
                ptr_nxt    = length_r;
                lim_nxt    = cur_c;
              end
            end
          endcase
        end
      end
      OP_FOCUS: begin
        focus_nxt  = FM_EDIT;
        cursor_nxt = 8'd0;
        length_nxt = 8'd0;
      end
      OP_RELEASE: begin
        focus_nxt = FM_IDLE;
      end
      default: begin
        rd_ok_nxt = (item.read_index < length_r);
      end
    endcase
  end

  // Update edit state on accept
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focus_r  <= FM_IDLE;
      cursor_r <= 8'd0;
      length_r <= 8'd0;
      ins_r    <= 1'b0;
    end else if (cmd.accept) begin
      focus_r  <= focus_nxt;
      cursor_r <= cursor_nxt;
      length_r <= length_nxt;
      ins_r    <= ins_nxt;
    end
  end

  // Capture request payload, set up the shift window and step its pointer on each write
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      handled_r <= handled_nxt;
      rd_ok_r   <= rd_ok_nxt;
      ch_r      <= item.typed_char;
      ptr_r     <= ptr_nxt;
      lim_r     <= lim_nxt;
    end else if (cmd.wr) begin
      ptr_r <= ins_r ? (ptr_r - 8'd1) : (ptr_r + 8'd1);
    end
  end

  assign sts.start_shift = ins_nxt || del_nxt;
  assign sts.busy        = (ptr_r != lim_r);

  // Select memory addresses: read the neighbor, write it one slot over, then on insert drop in the char
  always_comb begin
    mem_re = 1'b0;
    mem_we = 1'b0;
    raddr  = AW'(item.read_index);
    waddr  = AW'(ptr_r);
    wdata  = rdata_r;
    if (cmd.accept) begin
      mem_re = (item.opcode == OP_READ);
    end else if (cmd.step && sts.busy) begin
      mem_re = 1'b1;
      raddr  = ins_r ? AW'(ptr_r - 8'd1) : AW'(ptr_r + 8'd1);
    end else if (cmd.step && ins_r) begin
      mem_we = 1'b1;
      waddr  = AW'(lim_r);
      wdata  = ch_r;
    end else if (cmd.wr) begin
      mem_we = 1'b1;
    end
  end

  // Text memory with registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= wdata;
    if (mem_re) rdata_r <= mem[raddr];
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      result_r.handled        <= handled_r;
      result_r.commit_pending <= (focus_r == FM_COMMIT);
      result_r.editing        <= (focus_r == FM_EDIT);
      result_r.cursor_pos     <= cursor_r;
      result_r.text_length    <= length_r;
      result_r.read_char      <= rd_ok_r ? rdata_r : 8'd0;
    end
  end

  assign sts.out_free = !out_valid_r || out_ready;
  assign out_valid    = out_valid_r;
  assign result       = result_r;

endmodule

// File: hw/rtl/line_edit_buffer.sv
// Top level of the line edit buffer.
// Single-line text field with a cursor, fed by key, focus, release and read requests; each
// request gives one result with the edit state after it. A request that moves no text goes
// from accept to the result register once the output is free. Insert and delete shift the
// tail through the one text memory port pair, a read and a write per character moved after
// the edit point, then an insert writes the typed char. A read request passes through the
// registered memory read first. The next request is taken once the previous one has
// reached the result register, even while that result still waits. The text memory needs
// no clearing after reset: only positions below the current length are ever used.
module line_edit_buffer #(
  parameter int unsigned BUF_DEPTH = leb_pkg::BUF_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [7:0] cfg_data,
  leb_in_if.sink     in_req,
  leb_out_if.source  out_rsp
);
  import leb_pkg::*;

  leb_item_t   item;
  leb_result_t result;
  leb_cmd_t    cmd;
  leb_status_t sts;
  logic        in_ready;
  logic        out_valid;

  // Pack the request payload
  assign item.opcode     = in_req.opcode;
  assign item.key_class  = in_req.key_class;
  assign item.key_code   = in_req.key_code;
  assign item.typed_char = in_req.typed_char;
  assign item.pressed    = in_req.pressed;
  assign item.read_index = in_req.read_index;
  assign in_req.ready    = in_ready;

  leb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  leb_dp #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .item      (item),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_rsp.ready),
    .result    (result)
  );

  // Drive the result channel
  assign out_rsp.valid          = out_valid;
  assign out_rsp.handled        = result.handled;
  assign out_rsp.commit_pending = result.commit_pending;
  assign out_rsp.editing        = result.editing;
  assign out_rsp.cursor_pos     = result.cursor_pos;
  assign out_rsp.text_length    = result.text_length;
  assign out_rsp.read_char      = result.read_char;

endmodule

// File: hw/rtl/leb_checker.sv
// Port-level assertions of the line edit buffer and their bind.
module leb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       handled,
  input logic       commit_pending,
  input logic       editing,
  input logic [7:0] cursor_pos,
  input logic [7:0] text_length
);

  // A waiting result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before it was taken");

  // Cursor never passes the end of the text
  a_cursor_in_text: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> cursor_pos <= text_length)
    else $error("cursor beyond text length");

  // Editing and commit pending exclude each other
  a_mode_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(editing && commit_pending))
    else $error("editing and commit pending both set");

  // A consumed key leaves the field in editing
  a_handled_editing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && handled |-> editing)
    else $error("key consumed outside editing");

endmodule

bind line_edit_buffer leb_checker u_leb_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_rsp.valid),
  .out_ready      (out_rsp.ready),
  .handled        (out_rsp.handled),
  .commit_pending (out_rsp.commit_pending),
  .editing        (out_rsp.editing),
  .cursor_pos     (out_rsp.cursor_pos),
  .text_length    (out_rsp.text_length)
);

// File: tb/tb.sv
// Self-checking testbench for the line edit buffer: directed and random key sessions.
`timescale 1ns / 1ps

module tb;
  import leb_pkg::*;

  localparam int unsigned BUF_DEPTH = BUF_DEPTH_DEF;
  localparam int unsigned CAPACITY = (BUF_DEPTH < 255) ? BUF_DEPTH : 255;
  localparam int unsigned PHASE_ITEMS = 335;
  localparam int unsigned DRAIN_CYCLES = 600;
  localparam int unsigned CYCLE_LIMIT = 4000000;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [7:0] cfg_data;

  leb_in_if  in_ch ();
  leb_out_if out_ch ();

  line_edit_buffer dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data),
    .in_req  (in_ch.sink),
    .out_rsp (out_ch.source)
  );

  // Edit state as the block should hold it
  logic [1:0] mode_model;
  logic [7:0] cursor_model;
  logic [7:0] length_model;
  logic [7:0] limit_model;
  logic [7:0] text_model [0:BUF_DEPTH-1];

  leb_item_t   request_q [$];
  leb_result_t due_results [$];

  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;
  int unsigned queued_count;
  int unsigned mismatch_count;
  int unsigned cycle_count;
  bit          req_taken;

  // Run the clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Update the edit state for one request and return the result it gives
  function automatic leb_result_t apply_request(input leb_item_t rq);
    leb_result_t res;
    logic        handled;
    logic [7:0]  rd;
    handled = 1'b0;
    rd = 8'd0;
    case (rq.opcode)
      OP_KEY: begin
        if (mode_model == FM_EDIT) begin
          if (rq.key_class == KC_ENTER) begin
            mode_model = FM_COMMIT;
          end else if (rq.key_class != KC_OTHER || (rq.typed_char != 8'd0 &&
                       rq.key_code >= KEY_LOW && rq.key_code <= KEY_HIGH)) begin
            handled = 1'b1;
            if (rq.pressed) begin
              if (cursor_model > length_model) cursor_model = length_model;
              case (rq.key_class)
                KC_HOME: cursor_model = 8'd0;
                KC_END:  cursor_model = length_model;
                KC_DEL: begin
                  if (cursor_model < length_model) begin
                    for (int unsigned i = cursor_model; i + 1 < length_model; i++)
                      text_model[i] = text_model[i+1];
                    length_model = length_model - 8'd1;
                  end
                end
                KC_BKSP: begin
                  if (cursor_model > 8'd0) begin
                    cursor_model = cursor_model - 8'd1;
                    for (int unsigned i = cursor_model; i + 1 < length_model; i++)
                      text_model[i] = text_model[i+1];
                    length_model = length_model - 8'd1;
                  end
                end
                KC_LEFT: begin
                  if (cursor_model > 8'd0) cursor_model = cursor_model - 8'd1;
                end
                KC_RIGHT: begin
                  if (cursor_model < length_model) cursor_model = cursor_model + 8'd1;
                end
                default: begin
                  if (cursor_model < limit_model && length_model < CAPACITY) begin
                    for (int unsigned i = length_model; i > cursor_model; i--)
                      text_model[i] = text_model[i-1];
                    text_model[cursor_model] = rq.typed_char;
                    length_model = length_model + 8'd1;
                    cursor_model = cursor_model + 8'd1;
                  end
                end
              endcase
            end
          end
        end
      end
      OP_FOCUS: begin
        length_model = 8'd0;
        cursor_model = 8'd0;
        mode_model = FM_EDIT;
      end
      OP_RELEASE: mode_model = FM_IDLE;
      default: begin
        if (rq.read_index < length_model) rd = text_model[rq.read_index];
      end
    endcase
    res.handled = handled;
    res.commit_pending = (mode_model == FM_COMMIT);
    res.editing = (mode_model == FM_EDIT);
    res.cursor_pos = cursor_model;
    res.text_length = length_model;
    res.read_char = rd;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] %s: got %0d, want %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // Drive requests and result ready at the falling edge
  always @(negedge clk) begin : drive_requests
    leb_item_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
      if (in_ch.valid && !req_taken) begin
        // hold the request until it is taken
      end else if (request_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
        nxt = request_q.pop_front();
        in_ch.valid      <= 1'b1;
        in_ch.opcode     <= nxt.opcode;
        in_ch.key_class  <= nxt.key_class;
        in_ch.key_code   <= nxt.key_code;
        in_ch.typed_char <= nxt.typed_char;
        in_ch.pressed    <= nxt.pressed;
        in_ch.read_index <= nxt.read_index;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
    req_taken = 1'b0;
  end

  // Predict on accepted requests, check results at the rising edge
  always @(posedge clk) begin : check_results
    leb_item_t   rq;
    leb_result_t want;
    if (!rst_n) begin
      mode_model = FM_IDLE;
      cursor_model = 8'd0;
      length_model = 8'd0;
      limit_model = MAX_LENGTH_RST;
    end else begin
      if (cfg_we) limit_model = cfg_data;
      if (in_ch.valid && in_ch.ready) begin
        rq.opcode     = in_ch.opcode;
        rq.key_class  = in_ch.key_class;
        rq.key_code   = in_ch.key_code;
        rq.typed_char = in_ch.typed_char;
        rq.pressed    = in_ch.pressed;
        rq.read_index = in_ch.read_index;
        due_results.push_back(apply_request(rq));
        req_taken = 1'b1;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (due_results.size() == 0) begin
          report_mismatch("result with none due, text_length", out_ch.text_length, 0);
        end else begin
          want = due_results.pop_front();
          if (out_ch.handled !== want.handled)
            report_mismatch("handled", out_ch.handled, want.handled);
          if (out_ch.commit_pending !== want.commit_pending)
            report_mismatch("commit_pending", out_ch.commit_pending, want.commit_pending);
          if (out_ch.editing !== want.editing)
            report_mismatch("editing", out_ch.editing, want.editing);
          if (out_ch.cursor_pos !== want.cursor_pos)
            report_mismatch("cursor_pos", out_ch.cursor_pos, want.cursor_pos);
          if (out_ch.text_length !== want.text_length)
            report_mismatch("text_length", out_ch.text_length, want.text_length);
          if (out_ch.read_char !== want.read_char)
            report_mismatch("read_char", out_ch.read_char, want.read_char);
        end
      end
    end
  end

  // Request builders: unused fields stay random
  function automatic leb_item_t key_item(input logic [2:0] kc, input logic [9:0] code,
                                         input logic [7:0] ch, input logic down);
    leb_item_t it;
    it = leb_item_t'($urandom);
    it.opcode = OP_KEY;
    it.key_class = kc;
    it.key_code = code;
    it.typed_char = ch;
    it.pressed = down;
    return it;
  endfunction

  function automatic leb_item_t op_item(input logic [1:0] op, input logic [7:0] idx);
    leb_item_t it;
    it = leb_item_t'($urandom);
    it.opcode = op;
    it.read_index = idx;
    return it;
  endfunction

  function automatic leb_item_t typed_item();
    return key_item(KC_OTHER, 10'($urandom_range(32, 127)), 8'($urandom_range(1, 255)), 1'b1);
  endfunction

  task automatic push_req(input leb_item_t it);
    request_q.push_back(it);
    queued_count++;
  endtask

  // Hold until every request has been taken and answered
  task automatic wait_drained();
    while (request_q.size() != 0 || (in_ch.valid && !req_taken) || due_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_limit(input logic [7:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Short checks of the edges and of every key class
  task automatic add_directed();
    push_req(key_item(KC_HOME, 10'd0, 8'd0, 1'b1));
    push_req(op_item(OP_READ, 8'd0));
    push_req(op_item(OP_FOCUS, 8'd0));
    push_req(key_item(KC_OTHER, 10'd65, 8'h41, 1'b1));
    push_req(key_item(KC_OTHER, 10'd32, 8'hFF, 1'b1));
    push_req(key_item(KC_OTHER, 10'd127, 8'h01, 1'b1));
    push_req(key_item(KC_OTHER, 10'd31, 8'h41, 1'b1));
    push_req(key_item(KC_OTHER, 10'd128, 8'h41, 1'b1));
    push_req(key_item(KC_OTHER, 10'd65, 8'h00, 1'b1));
    push_req(key_item(KC_OTHER, 10'd1023, 8'hFF, 1'b0));
    push_req(key_item(KC_LEFT, 10'd0, 8'd0, 1'b1));
    push_req(key_item(KC_OTHER, 10'd66, 8'h42, 1'b1));
    push_req(key_item(KC_HOME, 10'd0, 8'd0, 1'b1));
    push_req(key_item(KC_LEFT, 10'd0, 8'd0, 1'b1));
    push_req(key_item(KC_BKSP, 10'd0, 8'd0, 1'b1));
    push_req(key_item(KC_END, 10'd0, 8'd0, 1'b1));
    push_req(key_item(KC_RIGHT, 10'd0, 8'd0, 1'b1));
    push_req(key_item(KC_DEL, 10'd0, 8'd0, 1'b1));
    push_req(key_item(KC_LEFT, 10'd0, 8'd0, 1'b1));
    push_req(key_item(KC_DEL, 10'd0, 8'd0, 1'b1));
    push_req(key_item(KC_BKSP, 10'd0, 8'd0, 1'b1));
    push_req(key_item(KC_RIGHT, 10'd0, 8'd0, 1'b0));
    push_req(op_item(OP_READ, 8'd0));
    push_req(op_item(OP_READ, 8'd255));
    push_req(key_item(KC_ENTER, 10'd0, 8'd0, 1'b1));
    push_req(key_item(KC_HOME, 10'd0, 8'd0, 1'b1));
    push_req(op_item(OP_FOCUS, 8'd0));
    push_req(key_item(KC_ENTER, 10'd0, 8'd0, 1'b0));
    push_req(op_item(OP_RELEASE, 8'd0));
  endtask

  // Fill the field to capacity, then edit at the far ends
  task automatic add_fill_session();
    push_req(op_item(OP_FOCUS, 8'd0));
    for (int i = 0; i < CAPACITY + 2; i++) push_req(typed_item());
    push_req(op_item(OP_READ, 8'd254));
    push_req(op_item(OP_READ, 8'd255));
    push_req(key_item(KC_HOME, 10'd0, 8'd0, 1'b1));
    push_req(typed_item());
    push_req(key_item(KC_DEL, 10'd0, 8'd0, 1'b1));
    push_req(typed_item());
    push_req(key_item(KC_RIGHT, 10'd0, 8'd0, 1'b1));
    push_req(key_item(KC_BKSP, 10'd0, 8'd0, 1'b1));
    push_req(key_item(KC_END, 10'd0, 8'd0, 1'b1));
    push_req(key_item(KC_BKSP, 10'd0, 8'd0, 1'b1));
    push_req(op_item(OP_READ, 8'd253));
    push_req(op_item(OP_RELEASE, 8'd0));
  endtask

  // One session of random keys, mostly opened with a focus request, with some noise
  task automatic add_session();
    int unsigned n;
    int unsigned r;
    leb_item_t   it;
    if ($urandom_range(0, 9) != 0) push_req(op_item(OP_FOCUS, 8'($urandom)));
    n = $urandom_range(1, 28);
    for (int unsigned k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        push_req(typed_item());
      end else if (r < 75) begin
        push_req(key_item(3'($urandom_range(1, 6)), 10'($urandom), 8'($urandom), 1'b1));
      end else if (r < 81) begin
        it = typed_item();
        it.key_class = 3'($urandom_range(1, 7));
        it.pressed = 1'b0;
        push_req(it);
      end else if (r < 88) begin
        push_req(leb_item_t'($urandom));
      end else if (r < 95) begin
        push_req(op_item(OP_READ, ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                               : 8'($urandom_range(0, 31))));
      end else if (r < 98) begin
        push_req(key_item(KC_ENTER, 10'($urandom), 8'($urandom), 1'($urandom)));
      end else begin
        push_req(op_item(OP_RELEASE, 8'($urandom)));
      end
    end
    r = $urandom_range(0, 4);
    for (int unsigned k = 0; k < r; k++) push_req(op_item(OP_READ, 8'($urandom_range(0, 31))));
    if ($urandom_range(0, 1) == 0) push_req(op_item(OP_RELEASE, 8'($urandom)));
  endtask

  // Stop a hung run
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Mismatches found");
    $finish;
  end

  // Reset, then run the phases of settings and idling
  initial begin : run_phases
    logic [7:0] limits [6];
    int unsigned target;
    limits = '{8'd255, 8'd0, 8'd1, 8'd0, 8'd8, 8'd255};
    limits[3] = 8'($urandom_range(2, 254));
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_data = 8'd0;
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_KEY;
    in_ch.key_class = KC_ENTER;
    in_ch.key_code = 10'd0;
    in_ch.typed_char = 8'd0;
    in_ch.pressed = 1'b0;
    in_ch.read_index = 8'd0;
    out_ch.ready = 1'b0;
    src_idle_pct = 11;
    sink_idle_pct = 79;
    queued_count = 0;
    mismatch_count = 0;
    req_taken = 1'b0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < 6; ph++) begin
      wait_drained();
      write_limit(limits[ph]);
      if (ph < 2) begin
        src_idle_pct = 11;
        sink_idle_pct = 79;
      end else if (ph < 4) begin
        src_idle_pct = 79;
        sink_idle_pct = 11;
      end else begin
        src_idle_pct = 0;
        sink_idle_pct = 0;
      end
      if (ph == 0) add_directed();
      target = queued_count + PHASE_ITEMS;
      while (queued_count < target - PHASE_ITEMS / 2) add_session();
      // pause the sender until every result is back
      wait_drained();
      if (ph == 0 || ph == 5) add_fill_session();
      while (queued_count < target) add_session();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
